// ===== rtl/aps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;
  localparam int DEF_SLOTS = 64;
  localparam int CLASSES = 5;

  localparam logic [1:0] KIND_SET_RUN = 2'd0;
  localparam logic [1:0] KIND_SET_PRI = 2'd1;
  localparam logic [1:0] KIND_ROUND   = 2'd2;
  localparam logic [1:0] KIND_BURST   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_PRI  = 3'd1;
  localparam logic [2:0] ST_NONE     = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_NO_DISP  = 3'd4;

  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_BOOST  = 3'd1;
  localparam logic [2:0] REG_STARVE = 3'd2;
  localparam logic [2:0] REG_BASEQ  = 3'd3;
  localparam logic [2:0] REG_MINQ   = 3'd4;
  localparam logic [2:0] REG_MAXQ   = 3'd5;

  localparam logic [7:0] MAX_PRI = 8'd200;

  typedef struct packed {
    logic clear;
    logic load;
    logic age_step;
    logic pick_step;
    logic finish;
  } aps_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       running_valid;
  } aps_stat_t;

  function automatic logic [2:0] class_of(input logic [7:0] p);
    if (p < 8'd40) return 3'd0;
    else if (p < 8'd80) return 3'd1;
    else if (p < 8'd120) return 3'd2;
    else if (p < 8'd160) return 3'd3;
    else return 3'd4;
  endfunction

  function automatic logic [15:0] clamp_q(input logic [15:0] q, input logic [5:0] mn,
                                          input logic [5:0] mx);
    logic [15:0] r;
    r = q;
    if (r < {10'd0, mn}) r = {10'd0, mn};
    if (r > {10'd0, mx}) r = {10'd0, mx};
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/aps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aps_ctrl import aps_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire aps_stat_t stat,
  output aps_cmd_t       cmd
);
  localparam int IW = $clog2(SLOTS);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AGE  = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0] state;
  logic [IW-1:0] idx;
  logic last;

  assign last = (idx == IW'(SLOTS - 1));
  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.clear = (state == S_CLR);
    cmd.load = (state == S_IDLE) && start;
    cmd.age_step = (state == S_AGE);
    cmd.pick_step = (state == S_PICK);
    cmd.finish = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          idx <= last ? '0 : idx + 1'b1;
          if (last) state <= S_IDLE;
        end
        S_IDLE: begin
          idx <= '0;
          if (start) begin
            if (stat.kind == KIND_ROUND && !stat.running_valid) state <= S_AGE;
            else state <= S_DONE;
          end
        end
        S_AGE: begin
          idx <= last ? '0 : idx + 1'b1;
          if (last) state <= S_PICK;
        end
        S_PICK: begin
          idx <= last ? '0 : idx + 1'b1;
          if (last) state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/aps_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aps_datapath import aps_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire aps_cmd_t    cmd,
  output aps_stat_t        stat,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [1:0]  kind,
  input  wire logic [5:0]  slot,
  input  wire logic        runnable,
  input  wire logic [7:0]  priority_req,
  input  wire logic [15:0] burst_ticks,
  output logic             done,
  output logic [2:0]       status,
  output logic             dispatched,
  output logic [5:0]       chosen_slot,
  output logic [5:0]       quantum,
  output logic [7:0]       chosen_priority,
  output logic [15:0]      burst_avg
);
  localparam int IW = $clog2(SLOTS);

  logic [15:0] age_limit, starve_limit;
  logic [7:0]  age_drop;
  logic [5:0]  quant_base, quant_lo, quant_hi;

  logic [SLOTS-1:0] run_f;
  logic [7:0]  cur_p [SLOTS];
  logic [7:0]  base_p [SLOTS];
  logic [15:0] wait_c [SLOTS];
  logic [15:0] avg_r [CLASSES];
  logic running_valid;
  logic [IW-1:0] running_slot;

  logic [1:0]  k_r;
  logic [5:0]  s_r;
  logic        run_r;
  logic [7:0]  p_r;
  logic [15:0] t_r;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_nx;
  logic found;
  logic [IW-1:0] best;
  logic [7:0] best_p;
  logic [15:0] best_w;

  // Slot table read port; the data register holds the entry at raddr of the previous cycle.
  logic [IW-1:0] raddr;
  logic [7:0]  cur_rd, base_rd;
  logic [15:0] wait_rd;

  // Slot table write port.
  logic          cur_we, base_we, wait_we;
  logic [IW-1:0] cur_wa, wait_wa;
  logic [7:0]    cur_wd;
  logic [15:0]   wait_wd;

  assign idx_nx = (idx == IW'(SLOTS - 1)) ? '0 : idx + 1'b1;

  // The scan reads one slot ahead so the data for idx is ready when idx is worked on.
  // Outside a scan the running slot is read, ready for a burst end.
  always_comb begin
    if (cmd.age_step || cmd.pick_step) raddr = idx_nx;
    else if (cmd.load && kind == KIND_ROUND) raddr = '0;
    else raddr = running_slot;
  end

  // Aging of the slot under the scan pointer.
  logic [15:0] w_inc;
  logic [7:0]  p_age;
  logic [15:0] w_age;
  always_comb begin
    w_inc = (wait_rd != 16'hFFFF) ? wait_rd + 16'd1 : wait_rd;
    p_age = cur_rd;
    w_age = w_inc;
    if (w_inc >= starve_limit) begin
      p_age = '0;
      w_age = '0;
    end else if (w_inc >= age_limit) begin
      p_age = (cur_rd > age_drop) ? cur_rd - age_drop : 8'd0;
      w_age = '0;
    end
  end

  logic better;
  assign better = run_f[idx] && (!found || cur_rd < best_p ||
                  (cur_rd == best_p && wait_rd > best_w));

  // Quantum for the chosen priority.
  logic [15:0] qb, qs;
  always_comb begin
    qb = avg_r[class_of(best_p)];
    qb = clamp_q((qb != 0) ? qb : {10'd0, quant_base}, quant_lo, quant_hi);
    if (best_p < 8'd80) qs = (qb * 16'd3) >> 1;
    else if (best_p > 8'd159) qs = qb >> 1;
    else qs = qb;
    qs = clamp_q(qs, quant_lo, quant_hi);
  end

  // Burst end arithmetic for the running slot.
  logic [15:0] a_t;
  logic [7:0]  rp, rb, np, dd;
  logic [2:0]  rc;
  logic [19:0] mix;
  logic [15:0] navg;
  always_comb begin
    a_t = (t_r == 0) ? 16'd1 : t_r;
    rp = cur_rd;
    rb = base_rd;
    rc = class_of(rp);
    mix = 20'd3 * {4'd0, a_t} + 20'd5 * {4'd0, avg_r[rc]};
    navg = (avg_r[rc] == 0) ? a_t : mix[18:3];
    np = rp;
    dd = '0;
    if (rp < rb) begin
      dd = (rb - rp) >> 1;
      if (dd == 0) dd = 8'd1;
      np = (rp + dd > rb) ? rb : rp + dd;
    end
  end

  always_comb begin
    cur_we = 1'b0;
    base_we = 1'b0;
    wait_we = 1'b0;
    cur_wa = idx;
    wait_wa = idx;
    cur_wd = '0;
    wait_wd = '0;
    if (cmd.clear) begin
      cur_we = 1'b1;
      base_we = 1'b1;
      wait_we = 1'b1;
    end else if (cmd.age_step) begin
      cur_we = run_f[idx];
      wait_we = run_f[idx];
      cur_wd = p_age;
      wait_wd = w_age;
    end else if (cmd.finish) begin
      unique case (k_r)
        KIND_SET_PRI: begin
          if (p_r <= MAX_PRI && {2'd0, s_r} < 8'(SLOTS)) begin
            cur_we = 1'b1;
            base_we = 1'b1;
            cur_wa = s_r[IW-1:0];
            cur_wd = p_r;
          end
        end
        KIND_ROUND: begin
          if (!running_valid && found) begin
            wait_we = 1'b1;
            wait_wa = best;
          end
        end
        KIND_BURST: begin
          if (running_valid) begin
            cur_we = 1'b1;
            wait_we = 1'b1;
            cur_wa = running_slot;
            wait_wa = running_slot;
            cur_wd = np;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur_rd <= cur_p[raddr];
    base_rd <= base_p[raddr];
    wait_rd <= wait_c[raddr];
    if (cur_we) cur_p[cur_wa] <= cur_wd;
    if (base_we) base_p[cur_wa] <= cur_wd;
    if (wait_we) wait_c[wait_wa] <= wait_wd;
  end

  assign stat.kind = kind;
  assign stat.running_valid = running_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r <= kind; s_r <= slot; run_r <= runnable; p_r <= priority_req; t_r <= burst_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= 16'd200; age_drop <= 8'd20; starve_limit <= 16'd500;
      quant_base <= 6'd5; quant_lo <= 6'd1; quant_hi <= 6'd20;
      run_f <= '0; running_valid <= 1'b0; running_slot <= '0;
      idx <= '0; found <= 1'b0; done <= 1'b0;
      for (int c = 0; c < CLASSES; c++) avg_r[c] <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESH: age_limit <= cfg_data;
          REG_BOOST:  age_drop <= cfg_data[7:0];
          REG_STARVE: starve_limit <= cfg_data;
          REG_BASEQ:  quant_base <= cfg_data[5:0];
          REG_MINQ:   quant_lo <= cfg_data[5:0];
          REG_MAXQ:   quant_hi <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        idx <= '0;
        found <= 1'b0;
      end
      if (cmd.clear || cmd.age_step) idx <= idx_nx;
      if (cmd.pick_step) begin
        if (better) begin
          found <= 1'b1; best <= idx; best_p <= cur_rd; best_w <= wait_rd;
        end
        idx <= idx_nx;
      end
      if (cmd.finish) begin
        done <= 1'b1;
        status <= ST_OK; dispatched <= 1'b0; chosen_slot <= '0; quantum <= '0;
        chosen_priority <= '0; burst_avg <= '0;
        unique case (k_r)
          KIND_SET_RUN: if ({2'd0, s_r} < 8'(SLOTS)) run_f[s_r[IW-1:0]] <= run_r;
          KIND_SET_PRI: if (p_r > MAX_PRI) status <= ST_BAD_PRI;
          KIND_ROUND: begin
            if (running_valid) status <= ST_BUSY;
            else if (!found) status <= ST_NONE;
            else begin
              dispatched <= 1'b1;
              chosen_slot <= 6'(best);
              quantum <= qs[5:0];
              chosen_priority <= best_p;
              run_f[best] <= 1'b0;
              running_valid <= 1'b1;
              running_slot <= best;
            end
          end
          default: begin
            if (!running_valid) status <= ST_NO_DISP;
            else begin
              avg_r[rc] <= navg;
              run_f[running_slot] <= run_r;
              running_valid <= 1'b0;
              chosen_slot <= 6'(running_slot);
              chosen_priority <= np;
              burst_avg <= navg;
            end
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/aging_priority_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Priority scheduler with aging and a per-class burst average quantum.
// A command word is taken when start is high and busy is low; busy then
// stays high and goes low in the same cycle as done shows its result.
// Every command gives one result word, on the result ports for one cycle
// while done is high. The receiver cannot stall; it must take it then.
// Set runnable, set priority and burst done skip the scan. A scheduling
// round makes one pass over the slot table that ages each runnable slot and
// a second pass that finds the best candidate, both one slot per cycle
// through the shared scan pointer; a round issued while a dispatch is
// outstanding skips both passes. Configuration is written through
// cfg_we/cfg_index/cfg_data while idle; the user must keep to this; the
// block does not enforce it. Reset (rst, synchronous) clears the class
// averages and the dispatch record and restores the configuration defaults;
// busy then stays high while the slot table is cleared one slot per cycle.
module aging_priority_scheduler import aps_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [1:0]  kind,
  input  wire logic [5:0]  slot,
  input  wire logic        runnable,
  input  wire logic [7:0]  priority_req,
  input  wire logic [15:0] burst_ticks,
  output logic             done,
  output logic [2:0]       status,
  output logic             dispatched,
  output logic [5:0]       chosen_slot,
  output logic [5:0]       quantum,
  output logic [7:0]       chosen_priority,
  output logic [15:0]      burst_avg
);
  aps_cmd_t  cmd;
  aps_stat_t stat;

  aps_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  aps_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .kind(kind), .slot(slot), .runnable(runnable), .priority_req(priority_req),
    .burst_ticks(burst_ticks), .done(done), .status(status), .dispatched(dispatched),
    .chosen_slot(chosen_slot), .quantum(quantum), .chosen_priority(chosen_priority),
    .burst_avg(burst_avg)
  );
endmodule
`default_nettype wire
